// ===== rtl/core/evr_pkg.sv =====
// Types, constants and the sine table shared by the Euler vertex rotation block.
`timescale 1ns / 1ps

package evr_pkg;

   localparam int unsigned NUM_AXES = 3;

   // Coordinate and angle slots inside a pipeline stage.
   localparam int unsigned AXIS_X = 0;
   localparam int unsigned AXIS_Y = 1;
   localparam int unsigned AXIS_Z = 2;

   localparam logic [1:0] CMD_X   = 2'd0;
   localparam logic [1:0] CMD_Y   = 2'd1;
   localparam logic [1:0] CMD_Z   = 2'd2;
   localparam logic [1:0] CMD_XYZ = 2'd3;

   localparam logic [1:0] AXIS_CMD [NUM_AXES] = '{CMD_X, CMD_Y, CMD_Z};

   localparam int unsigned QUARTER_LEN = 65;
   localparam logic [7:0]  QUARTER_TURN = 8'd64;
   localparam logic [6:0]  QUARTER_TOP  = 7'd64;

   // round(64*sin(2*pi*i/256)) for the first quarter turn, both ends included.
   localparam logic [6:0] QUARTER_SINE [QUARTER_LEN] = '{
      7'd0,  7'd2,  7'd3,  7'd5,  7'd6,  7'd8,  7'd9,  7'd11,
      7'd12, 7'd14, 7'd16, 7'd17, 7'd19, 7'd20, 7'd22, 7'd23,
      7'd24, 7'd26, 7'd27, 7'd29, 7'd30, 7'd32, 7'd33, 7'd34,
      7'd36, 7'd37, 7'd38, 7'd39, 7'd41, 7'd42, 7'd43, 7'd44,
      7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50, 7'd51, 7'd52,
      7'd53, 7'd54, 7'd55, 7'd56, 7'd56, 7'd57, 7'd58, 7'd59,
      7'd59, 7'd60, 7'd60, 7'd61, 7'd61, 7'd62, 7'd62, 7'd62,
      7'd63, 7'd63, 7'd63, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64,
      7'd64
   };

   typedef struct packed {
      logic [1:0]        cmd;
      logic signed [7:0] vx_in;
      logic signed [7:0] vy_in;
      logic signed [7:0] vz_in;
      logic [7:0]        angle_x;
      logic [7:0]        angle_y;
      logic [7:0]        angle_z;
   } req_type;

   typedef struct packed {
      logic signed [7:0] vx_out;
      logic signed [7:0] vy_out;
      logic signed [7:0] vz_out;
   } rsp_type;

   // Vertex in flight: coordinates and angles indexed by axis slot.
   typedef struct packed {
      logic [1:0]                cmd;
      logic [NUM_AXES-1:0][7:0]  crd;
      logic [NUM_AXES-1:0][7:0]  ang;
   } stage_type;

   // Per-axis controls carried from the multiply stage to the sum stage.
   typedef struct packed {
      logic apply;
      logic trunc;
      logic add_bs;
   } rot_ctl_type;

   function automatic logic signed [7:0] sine_q26(input logic [7:0] angle);
      logic [6:0] idx;
      logic [6:0] mag;
      begin
         idx = angle[6] ? (QUARTER_TOP - {1'b0, angle[5:0]}) : {1'b0, angle[5:0]};
         mag = QUARTER_SINE[idx];
         sine_q26 = angle[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   endfunction

   function automatic logic signed [7:0] cosine_q26(input logic [7:0] angle);
      logic [7:0] shifted;
      begin
         shifted = angle + QUARTER_TURN;
         cosine_q26 = sine_q26(shifted);
      end
   endfunction

   // Divide by 64 (floor, or toward zero) and wrap to 8 bits.
   function automatic logic [7:0] scale_q26(input logic signed [16:0] sum,
                                            input logic trunc);
      logic signed [16:0] adj;
      begin
         adj = (trunc && sum[16]) ? (sum + 17'sd63) : sum;
         scale_q26 = adj[13:6];
      end
   endfunction

endpackage

// ===== rtl/core/euler_vertex_rotation.sv =====
// Top level: pipelined X, Y, Z rotation of one 8-bit vertex per clock.
`timescale 1ns / 1ps

// Takes one vertex in every clock cycle; busy never rises. Each result is
// strobed on rsp_valid once it has passed all seven register stages: one input
// register, loaded by the accepting edge, then a multiply stage and a sum stage
// for each of the X, Y and Z axes, in that order. Results are strobed for a
// single cycle and the receiver cannot hold them off. Single-axis commands pass
// the other axes' stages untouched; the combined command runs all three in
// order X, Y, Z.
module euler_vertex_rotation
   import evr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   stage_type   ent_ff     [NUM_AXES+1];
   logic        ent_vld_ff [NUM_AXES+1];
   stage_type   mul_ff     [NUM_AXES];
   logic        mul_vld_ff [NUM_AXES];
   rot_ctl_type ctl_ff     [NUM_AXES];
   logic signed [15:0] pac_ff [NUM_AXES];
   logic signed [15:0] pbs_ff [NUM_AXES];
   logic signed [15:0] pas_ff [NUM_AXES];
   logic signed [15:0] pbc_ff [NUM_AXES];

   stage_type ent_in;

   assign busy = 1'b0;

   always_comb begin
      ent_in.cmd              = req_data.cmd;
      ent_in.crd[AXIS_X]      = req_data.vx_in;
      ent_in.crd[AXIS_Y]      = req_data.vy_in;
      ent_in.crd[AXIS_Z]      = req_data.vz_in;
      ent_in.ang[AXIS_X]      = req_data.angle_x;
      ent_in.ang[AXIS_Y]      = req_data.angle_y;
      ent_in.ang[AXIS_Z]      = req_data.angle_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff[0] <= 1'b0;
      end else begin
         ent_vld_ff[0] <= start & ~busy;
      end
      ent_ff[0] <= ent_in;
   end

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
      // Rotated pair: a' = a*c - b*s, b' = a*s + b*c.
      localparam int unsigned IA = (g + 1) % NUM_AXES;
      localparam int unsigned IB = (g + 2) % NUM_AXES;

      rot_ctl_type       ctl_in;
      logic signed [7:0] sin_v;
      logic signed [7:0] cos_v;
      logic signed [7:0] a_v;
      logic signed [7:0] b_v;
      logic signed [7:0] kb_v;
      logic signed [15:0] pac_in;
      logic signed [15:0] pbs_in;
      logic signed [15:0] pas_in;
      logic signed [15:0] pbc_in;
      logic signed [16:0] sa_v;
      logic signed [16:0] sb_v;
      stage_type          nxt_in;

      always_comb begin
         ctl_in.apply  = (ent_ff[g].cmd == AXIS_CMD[g]) || (ent_ff[g].cmd == CMD_XYZ);
         ctl_in.trunc  = (ent_ff[g].cmd == CMD_XYZ);
         // Combined Y step uses the 8-bit negated x, so -128 stays -128.
         ctl_in.add_bs = ctl_in.trunc && (g == AXIS_Y);
         sin_v  = sine_q26(ent_ff[g].ang[g]);
         cos_v  = cosine_q26(ent_ff[g].ang[g]);
         a_v    = $signed(ent_ff[g].crd[IA]);
         b_v    = $signed(ent_ff[g].crd[IB]);
         kb_v   = ctl_in.add_bs ? -b_v : b_v;
         pac_in = 16'(a_v) * 16'(cos_v);
         pbs_in = 16'(kb_v) * 16'(sin_v);
         pas_in = 16'(a_v) * 16'(sin_v);
         pbc_in = 16'(b_v) * 16'(cos_v);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            mul_vld_ff[g] <= 1'b0;
         end else begin
            mul_vld_ff[g] <= ent_vld_ff[g];
         end
         mul_ff[g] <= ent_ff[g];
         ctl_ff[g] <= ctl_in;
         pac_ff[g] <= pac_in;
         pbs_ff[g] <= pbs_in;
         pas_ff[g] <= pas_in;
         pbc_ff[g] <= pbc_in;
      end

      always_comb begin
         sa_v = 17'(pac_ff[g]) + (ctl_ff[g].add_bs ? 17'(pbs_ff[g]) : -17'(pbs_ff[g]));
         sb_v = 17'(pas_ff[g]) + 17'(pbc_ff[g]);
         nxt_in = mul_ff[g];
         if (ctl_ff[g].apply) begin
            nxt_in.crd[IA] = scale_q26(sa_v, ctl_ff[g].trunc);
            nxt_in.crd[IB] = scale_q26(sb_v, ctl_ff[g].trunc);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ent_vld_ff[g+1] <= 1'b0;
         end else begin
            ent_vld_ff[g+1] <= mul_vld_ff[g];
         end
         ent_ff[g+1] <= nxt_in;
      end
   end

   assign rsp_valid       = ent_vld_ff[NUM_AXES];
   assign rsp_data.vx_out = $signed(ent_ff[NUM_AXES].crd[AXIS_X]);
   assign rsp_data.vy_out = $signed(ent_ff[NUM_AXES].crd[AXIS_Y]);
   assign rsp_data.vz_out = $signed(ent_ff[NUM_AXES].crd[AXIS_Z]);

endmodule

// ===== test/tb.sv =====
// Self-checking bench for the Euler vertex rotation block, with random idle gaps on the sender.
`timescale 1ns / 1ps

module tb;
   import evr_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned NUM_PHASES = 4;
   localparam int unsigned PHASE_ITEMS = 490;

   // Sender idle percentage per phase.
   localparam int unsigned PHASE_IDLE [NUM_PHASES] = '{0, 77, 0, 18};

   // round(64*sin(2*pi*i/256)) over the first quarter turn.
   localparam int SINE_Q6 [65] = '{
       0,  2,  3,  5,  6,  8,  9, 11, 12, 14, 16, 17, 19, 20, 22, 23,
      24, 26, 27, 29, 30, 32, 33, 34, 36, 37, 38, 39, 41, 42, 43, 44,
      45, 46, 47, 48, 49, 50, 51, 52, 53, 54, 55, 56, 56, 57, 58, 59,
      59, 60, 60, 61, 61, 62, 62, 62, 63, 63, 63, 64, 64, 64, 64, 64,
      64
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   req_type     pending_vertices [$];
   rsp_type     expected_rotations [$];
   int unsigned idle_pct = 0;
   int unsigned calm_left = 0;
   int unsigned queued_total = 0;
   int unsigned accepted_total = 0;
   int unsigned checked_total = 0;
   int unsigned mismatch_count = 0;
   int unsigned stall_cycles = 0;
   int unsigned cmd_count [4] = '{0, 0, 0, 0};

   euler_vertex_rotation u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic int sine_of(logic [7:0] angle);
      int mag;
      logic [6:0] j;
      j = {1'b0, angle[5:0]};
      mag = angle[6] ? SINE_Q6[7'd64 - j] : SINE_Q6[j];
      return angle[7] ? -mag : mag;
   endfunction

   function automatic int cosine_of(logic [7:0] angle);
      logic [7:0] shifted;
      shifted = angle + 8'd64;
      return sine_of(shifted);
   endfunction

   function automatic int wrap_byte(int v);
      logic signed [7:0] b;
      b = v[7:0];
      return int'(b);
   endfunction

   function automatic rsp_type rotate_vertex(req_type r);
      int x, y, z, nx, ny, nz, s, c, negx, tx;
      rsp_type res;
      x = int'(r.vx_in);
      y = int'(r.vy_in);
      z = int'(r.vz_in);
      nx = x;
      ny = y;
      nz = z;
      case (r.cmd)
         CMD_X: begin
            s = sine_of(r.angle_x);
            c = cosine_of(r.angle_x);
            ny = wrap_byte((y * c - z * s) >>> 6);
            nz = wrap_byte((y * s + z * c) >>> 6);
         end
         CMD_Y: begin
            s = sine_of(r.angle_y);
            c = cosine_of(r.angle_y);
            nx = wrap_byte((x * c + z * s) >>> 6);
            nz = wrap_byte((-(x * s) + z * c) >>> 6);
         end
         CMD_Z: begin
            s = sine_of(r.angle_z);
            c = cosine_of(r.angle_z);
            nx = wrap_byte((x * c - y * s) >>> 6);
            ny = wrap_byte((x * s + y * c) >>> 6);
         end
         default: begin
            // combined mode truncates toward zero at every stage
            s = sine_of(r.angle_x);
            c = cosine_of(r.angle_x);
            ny = wrap_byte((y * c - z * s) / 64);
            nz = wrap_byte((y * s + z * c) / 64);
            s = sine_of(r.angle_y);
            c = cosine_of(r.angle_y);
            negx = wrap_byte(-x);
            nx = wrap_byte((x * c + nz * s) / 64);
            nz = wrap_byte((negx * s + nz * c) / 64);
            s = sine_of(r.angle_z);
            c = cosine_of(r.angle_z);
            tx = wrap_byte((nx * c - ny * s) / 64);
            ny = wrap_byte((nx * s + ny * c) / 64);
            nx = tx;
         end
      endcase
      res.vx_out = nx[7:0];
      res.vy_out = ny[7:0];
      res.vz_out = nz[7:0];
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH %s", msg);
      mismatch_count++;
   endtask

   task automatic queue_vertex(logic [1:0] cmd, int x, int y, int z,
                               int ax, int ay, int az);
      req_type r;
      r.cmd = cmd;
      r.vx_in = x[7:0];
      r.vy_in = y[7:0];
      r.vz_in = z[7:0];
      r.angle_x = ax[7:0];
      r.angle_y = ay[7:0];
      r.angle_z = az[7:0];
      pending_vertices.push_back(r);
      queued_total++;
   endtask

   function automatic int rand_coord();
      int corner [6] = '{-128, -127, -1, 0, 1, 127};
      if ($urandom_range(7) == 0)
         return corner[$urandom_range(5)];
      return $urandom_range(255) - 128;
   endfunction

   function automatic int rand_angle();
      int corner [6] = '{0, 63, 64, 128, 192, 255};
      if ($urandom_range(7) == 0)
         return corner[$urandom_range(5)];
      return $urandom_range(255);
   endfunction

   // Driver: record each transfer, then offer the next vertex or idle.
   always @(posedge clock) begin
      req_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rotations.push_back(rotate_vertex(req_data));
            cmd_count[req_data.cmd]++;
            accepted_total++;
         end
         if (!(start && busy)) begin
            if (calm_left > 0)
               calm_left--;
            else if ($urandom_range(63) == 0)
               calm_left = $urandom_range(30, 5);
            if (pending_vertices.size() != 0 &&
                (calm_left > 0 || $urandom_range(99) >= idle_pct)) begin
               nxt = pending_vertices.pop_front();
               req_data <= nxt;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each strobed result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rotations.size() == 0) begin
            report_mismatch($sformatf("unexpected result x=%0d y=%0d z=%0d",
                                      rsp_data.vx_out, rsp_data.vy_out, rsp_data.vz_out));
         end else begin
            want = expected_rotations.pop_front();
            if (rsp_data.vx_out !== want.vx_out)
               report_mismatch($sformatf("vx_out: got %0d, expected %0d (result %0d)",
                                         rsp_data.vx_out, want.vx_out, checked_total));
            if (rsp_data.vy_out !== want.vy_out)
               report_mismatch($sformatf("vy_out: got %0d, expected %0d (result %0d)",
                                         rsp_data.vy_out, want.vy_out, checked_total));
            if (rsp_data.vz_out !== want.vz_out)
               report_mismatch($sformatf("vz_out: got %0d, expected %0d (result %0d)",
                                         rsp_data.vz_out, want.vz_out, checked_total));
         end
         checked_total++;
      end
   end

   // Watchdog: give up after too long without any transfer.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", stall_cycles);
         $display("tb NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // field extremes, quadrant edges, floor on negative sums, -(-128) in the combined mode
      queue_vertex(CMD_X,    127,  127,  127,   0,   0,   0);
      queue_vertex(CMD_X,   -128, -128, -128,  64,   0,   0);
      queue_vertex(CMD_X,      5,   -3,    7,  32, 255, 255);
      queue_vertex(CMD_X,     -1,   -1,   -1,   1,   1,   1);
      queue_vertex(CMD_Y,   -128,  127, -128,   0, 192,   0);
      queue_vertex(CMD_Y,     -1,    0,   -1,   0, 255,   0);
      queue_vertex(CMD_Y,    127,  127,  127, 128, 128, 128);
      queue_vertex(CMD_Z,    127, -128,    0,   0,   0, 128);
      queue_vertex(CMD_Z,   -128, -128, -128, 255, 255,   1);
      queue_vertex(CMD_Z,      1,   -1,    1, 192, 192, 192);
      queue_vertex(CMD_XYZ, -128,    0,    0,   0,  64,   0);
      queue_vertex(CMD_XYZ, -128, -128, -128,  64,  64,  64);
      queue_vertex(CMD_XYZ,  127,  127,  127, 255, 255, 255);
      queue_vertex(CMD_XYZ,   -3,    5,   -7,  10, 200,  77);
      queue_vertex(CMD_XYZ,    0,    0,    0,   0,   0,   0);
      queue_vertex(CMD_XYZ, -128,  127, -128, 192, 128,  32);
      queue_vertex(CMD_XYZ, -128,    1,   -1,  96, 160, 224);

      for (int p = 0; p < NUM_PHASES; p++) begin
         idle_pct = PHASE_IDLE[p];
         for (int i = 0; i < PHASE_ITEMS; i++)
            queue_vertex(2'($urandom_range(3)), rand_coord(), rand_coord(), rand_coord(),
                         rand_angle(), rand_angle(), rand_angle());
         while (accepted_total != queued_total || expected_rotations.size() != 0)
            @(negedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (expected_rotations.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_rotations.size()));
      $display("rotated %0d vertices (X %0d, Y %0d, Z %0d, XYZ %0d), %0d results checked",
               accepted_total, cmd_count[CMD_X], cmd_count[CMD_Y], cmd_count[CMD_Z],
               cmd_count[CMD_XYZ], checked_total);
      $display("sender idle phases of 0, 77 and 18 percent, %0d mismatches", mismatch_count);
      if (mismatch_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
